### design/sha_pkg.sv
// shared types, constants and round functions for the sha-256 stream hasher
package sha_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_type;

   // one job handed from front to back
   typedef enum logic [1:0] {
      JOB_BLOCK = 2'd0,  // plain full block
      JOB_PAD   = 2'd1,  // final block, length in tail
      JOB_EXTRA = 2'd2   // padded block without length, another follows
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [511:0] block;
   } job_type;

   localparam int QueueDepth = 2;

   function automatic logic [31:0] init_hash(input logic [2:0] i);
      logic [31:0] r;
      case (i)
         3'd0: r = 32'h6a09e667;
         3'd1: r = 32'hbb67ae85;
         3'd2: r = 32'h3c6ef372;
         3'd3: r = 32'ha54ff53a;
         3'd4: r = 32'h510e527f;
         3'd5: r = 32'h9b05688c;
         3'd6: r = 32'h1f83d9ab;
         default: r = 32'h5be0cd19;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] round_k(input logic [5:0] i);
      logic [31:0] r;
      case (i)
         6'd0: r = 32'h428a2f98;  6'd1: r = 32'h71374491;
         6'd2: r = 32'hb5c0fbcf;  6'd3: r = 32'he9b5dba5;
         6'd4: r = 32'h3956c25b;  6'd5: r = 32'h59f111f1;
         6'd6: r = 32'h923f82a4;  6'd7: r = 32'hab1c5ed5;
         6'd8: r = 32'hd807aa98;  6'd9: r = 32'h12835b01;
         6'd10: r = 32'h243185be; 6'd11: r = 32'h550c7dc3;
         6'd12: r = 32'h72be5d74; 6'd13: r = 32'h80deb1fe;
         6'd14: r = 32'h9bdc06a7; 6'd15: r = 32'hc19bf174;
         6'd16: r = 32'he49b69c1; 6'd17: r = 32'hefbe4786;
         6'd18: r = 32'h0fc19dc6; 6'd19: r = 32'h240ca1cc;
         6'd20: r = 32'h2de92c6f; 6'd21: r = 32'h4a7484aa;
         6'd22: r = 32'h5cb0a9dc; 6'd23: r = 32'h76f988da;
         6'd24: r = 32'h983e5152; 6'd25: r = 32'ha831c66d;
         6'd26: r = 32'hb00327c8; 6'd27: r = 32'hbf597fc7;
         6'd28: r = 32'hc6e00bf3; 6'd29: r = 32'hd5a79147;
         6'd30: r = 32'h06ca6351; 6'd31: r = 32'h14292967;
         6'd32: r = 32'h27b70a85; 6'd33: r = 32'h2e1b2138;
         6'd34: r = 32'h4d2c6dfc; 6'd35: r = 32'h53380d13;
         6'd36: r = 32'h650a7354; 6'd37: r = 32'h766a0abb;
         6'd38: r = 32'h81c2c92e; 6'd39: r = 32'h92722c85;
         6'd40: r = 32'ha2bfe8a1; 6'd41: r = 32'ha81a664b;
         6'd42: r = 32'hc24b8b70; 6'd43: r = 32'hc76c51a3;
         6'd44: r = 32'hd192e819; 6'd45: r = 32'hd6990624;
         6'd46: r = 32'hf40e3585; 6'd47: r = 32'h106aa070;
         6'd48: r = 32'h19a4c116; 6'd49: r = 32'h1e376c08;
         6'd50: r = 32'h2748774c; 6'd51: r = 32'h34b0bcb5;
         6'd52: r = 32'h391c0cb3; 6'd53: r = 32'h4ed8aa4a;
         6'd54: r = 32'h5b9cca4f; 6'd55: r = 32'h682e6ff3;
         6'd56: r = 32'h748f82ee; 6'd57: r = 32'h78a5636f;
         6'd58: r = 32'h84c87814; 6'd59: r = 32'h8cc70208;
         6'd60: r = 32'h90befffa; 6'd61: r = 32'ha4506ceb;
         6'd62: r = 32'hbef9a3f7; default: r = 32'hc67178f2;
      endcase
      return r;
   endfunction

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

endpackage

### design/sha_front.sv
// front end: gathers bytes into blocks and builds padded jobs
module sha_front (
   input  logic            clock,
   input  logic            reset,
   input  sha_pkg::req_type req_data,
   input  logic            req_take,
   output logic            busy,
   output sha_pkg::job_type job,
   output logic            job_valid,
   input  logic            job_ready
);
   import sha_pkg::*;

   typedef enum logic [1:0] {
      FR_IDLE,
      FR_EXTRA,
      FR_FINAL
   } state_type;

   state_type    state_ff, state_in;
   logic [511:0] buf_ff, buf_in;
   logic [5:0]   fill_ff, fill_in;
   logic [60:0]  len_ff, len_in;
   logic [63:0]  bits_ff, bits_in;
   logic         extra_ff, extra_in;
   logic         end_pend_ff, end_pend_in;

   logic [511:0] with_byte, padded, final_blk, extra_blk;
   logic [5:0]   fill_b;
   logic [60:0]  len_b;

   assign busy = (state_ff != FR_IDLE);

   always_comb begin
      with_byte = buf_ff;
      fill_b    = fill_ff;
      len_b     = len_ff;
      if (req_data.byte_present) begin
         with_byte[511 - 8*fill_ff -: 8] = req_data.data_byte;
         fill_b = fill_ff + 6'd1;
         len_b  = len_ff + 61'd1;
      end
      // 0x80 at fill_b, zeros above
      padded = with_byte;
      for (int i = 0; i < 64; i++) begin
         if (6'(i) == fill_b) padded[511 - 8*i -: 8] = 8'h80;
         else if (6'(i) > fill_b) padded[511 - 8*i -: 8] = 8'h00;
      end
      extra_blk = padded;
      final_blk = {padded[511:64], len_b, 3'b000};
   end

   always_comb begin
      state_in    = state_ff;
      buf_in      = buf_ff;
      fill_in     = fill_ff;
      len_in      = len_ff;
      bits_in     = bits_ff;
      extra_in    = extra_ff;
      end_pend_in = end_pend_ff;
      job         = '{kind: JOB_BLOCK, block: buf_ff};
      job_valid   = 1'b0;
      case (state_ff)
         FR_IDLE: begin
            if (req_take) begin
               fill_in     = fill_b;
               len_in      = len_b;
               bits_in     = {len_b, 3'b000};
               end_pend_in = req_data.end_of_message && req_data.byte_present
                             && fill_b == 6'd0;
               if (req_data.end_of_message) begin
                  // full block from this byte goes out first
                  if (req_data.byte_present && fill_b == 6'd0) begin
                     buf_in   = with_byte;
                     extra_in = 1'b0;
                     state_in = FR_EXTRA;
                  end else if (fill_b >= 6'd56) begin
                     buf_in   = extra_blk;
                     extra_in = 1'b1;
                     state_in = FR_EXTRA;
                  end else begin
                     buf_in   = final_blk;
                     state_in = FR_FINAL;
                  end
               end else begin
                  buf_in = with_byte;
                  if (req_data.byte_present && fill_b == 6'd0) begin
                     extra_in = 1'b0;
                     state_in = FR_EXTRA;
                  end
               end
            end
         end
         FR_EXTRA: begin
            job_valid = 1'b1;
            job       = '{kind: (extra_ff ? JOB_EXTRA : JOB_BLOCK), block: buf_ff};
            if (job_ready) begin
               if (extra_ff) begin
                  buf_in   = {448'd0, bits_ff};
                  state_in = FR_FINAL;
               end else if (end_pend_ff) begin
                  // full block that ended the message: padding block follows
                  buf_in   = {8'h80, 440'd0, bits_ff};
                  state_in = FR_FINAL;
               end else begin
                  state_in = FR_IDLE;
               end
            end
         end
         FR_FINAL: begin
            job_valid = 1'b1;
            job       = '{kind: JOB_PAD, block: buf_ff};
            if (job_ready) begin
               fill_in  = 6'd0;
               len_in   = 61'd0;
               state_in = FR_IDLE;
            end
         end
         default: state_in = FR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      buf_ff  <= buf_in;
      bits_ff <= bits_in;
      if (reset) begin
         state_ff    <= FR_IDLE;
         fill_ff     <= '0;
         len_ff      <= '0;
         extra_ff    <= 1'b0;
         end_pend_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         len_ff      <= len_in;
         extra_ff    <= extra_in;
         end_pend_ff <= end_pend_in;
      end
   end
endmodule

### design/sha_job_queue.sv
// short queue of jobs between the front and back ends
module sha_job_queue (
   input  logic             clock,
   input  logic             reset,
   input  sha_pkg::job_type wr_job,
   input  logic             wr_valid,
   output logic             wr_ready,
   output sha_pkg::job_type rd_job,
   output logic             rd_valid,
   input  logic             rd_take
);
   import sha_pkg::*;

   job_type     slot_ff [QueueDepth];
   logic [$clog2(QueueDepth):0] count_ff;
   logic [$clog2(QueueDepth)-1:0] wp_ff, rp_ff;
   logic push, pop;

   assign wr_ready = (count_ff != QueueDepth[$clog2(QueueDepth):0]);
   assign rd_valid = (count_ff != '0);
   assign rd_job   = slot_ff[rp_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_take && rd_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wp_ff    <= '0;
         rp_ff    <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop)  rp_ff <= rp_ff + 1'b1;
         count_ff <= count_ff + {{$clog2(QueueDepth){1'b0}}, push}
                              - {{$clog2(QueueDepth){1'b0}}, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wp_ff] <= wr_job;
   end
endmodule

### design/sha_core.sv
// back end: 64-round compression, one round a cycle, digest output
module sha_core (
   input  logic             clock,
   input  logic             reset,
   input  sha_pkg::job_type job,
   input  logic             job_valid,
   output logic             job_take,
   output sha_pkg::rsp_type rsp_data,
   output logic             rsp_empty,
   input  logic             rsp_pop
);
   import sha_pkg::*;

   typedef enum logic [1:0] {
      CO_IDLE,
      CO_ROUND,
      CO_ADD,
      CO_OUT
   } state_type;

   state_type    state_ff;
   logic [31:0]  h_ff [8];
   logic [31:0]  v_ff [8];
   logic [31:0]  w_ff [16];
   logic [5:0]   rnd_ff;
   logic [2:0]   idx_ff;
   logic         last_ff;
   logic [31:0]  t1, t2, s0w, s1w, wnew, s1, s0, ch, maj;

   assign job_take  = (state_ff == CO_IDLE) && job_valid;
   assign rsp_empty = (state_ff != CO_OUT);
   assign rsp_data  = '{digest_word: h_ff[idx_ff], word_index: idx_ff,
                        last_word: (idx_ff == 3'd7)};

   always_comb begin
      s0w  = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1w  = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
      wnew = w_ff[0] + s0w + w_ff[9] + s1w;
      s1   = rotr(v_ff[4], 6) ^ rotr(v_ff[4], 11) ^ rotr(v_ff[4], 25);
      ch   = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      t1   = v_ff[7] + s1 + ch + round_k(rnd_ff) + w_ff[0];
      s0   = rotr(v_ff[0], 2) ^ rotr(v_ff[0], 13) ^ rotr(v_ff[0], 22);
      maj  = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t2   = s0 + maj;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CO_IDLE;
         idx_ff   <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
      end else begin
         case (state_ff)
            CO_IDLE: begin
               if (job_valid) begin
                  for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
                  for (int i = 0; i < 16; i++) w_ff[i] <= job.block[511 - 32*i -: 32];
                  rnd_ff   <= '0;
                  last_ff  <= (job.kind == JOB_PAD);
                  state_ff <= CO_ROUND;
               end
            end
            CO_ROUND: begin
               v_ff[7] <= v_ff[6];
               v_ff[6] <= v_ff[5];
               v_ff[5] <= v_ff[4];
               v_ff[4] <= v_ff[3] + t1;
               v_ff[3] <= v_ff[2];
               v_ff[2] <= v_ff[1];
               v_ff[1] <= v_ff[0];
               v_ff[0] <= t1 + t2;
               for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
               w_ff[15] <= wnew;
               rnd_ff   <= rnd_ff + 6'd1;
               if (rnd_ff == 6'd63) state_ff <= CO_ADD;
            end
            CO_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               idx_ff   <= '0;
               state_ff <= last_ff ? CO_OUT : CO_IDLE;
            end
            CO_OUT: begin
               if (rsp_pop) begin
                  idx_ff <= idx_ff + 3'd1;
                  if (idx_ff == 3'd7) begin
                     for (int i = 0; i < 8; i++) h_ff[i] <= init_hash(3'(i));
                     state_ff <= CO_IDLE;
                  end
               end
            end
            default: state_ff <= CO_IDLE;
         endcase
      end
   end
endmodule

### design/sha256_stream_hasher.sv
// top level of the sha-256 stream hasher
//
// channel    ports                         moves
// request    req_push, req_full, req_data   one byte and/or end mark
// response   rsp_pop, rsp_empty, rsp_data   one digest word, eight per message
//
// a byte request leaves the front end free; a request that fills a
// block or ends the message holds the front end until its jobs enter the queue
// the back end loads each block, runs its 64 rounds on the shared round logic,
// one round per cycle, then adds the working words into the chaining words
// reset is synchronous and returns the chaining words to the initial values
// a stalled response stalls only the back end; the two-job queue lets the
// front end keep gathering bytes meanwhile
module sha256_stream_hasher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  sha_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output sha_pkg::rsp_type rsp_data
);
   import sha_pkg::*;

   job_type f_job, q_job;
   logic    f_valid, f_ready, q_valid, q_take, front_busy;

   // the front end takes no request while it is handing off jobs
   assign req_full = front_busy;

   sha_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .req_take  (req_push && !req_full),
      .busy      (front_busy),
      .job       (f_job),
      .job_valid (f_valid),
      .job_ready (f_ready)
   );

   sha_job_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_job   (f_job),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .rd_job   (q_job),
      .rd_valid (q_valid),
      .rd_take  (q_take)
   );

   sha_core u_core (
      .clock     (clock),
      .reset     (reset),
      .job       (q_job),
      .job_valid (q_valid),
      .job_take  (q_take),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop)
   );

   // a job only leaves the front end when the queue has room
   assert property (@(posedge clock) disable iff (reset)
      (f_valid && !f_ready) |=> f_valid)
      else $error("front job dropped while queue full");

   // the last word of a digest always carries index seven
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.last_word) |-> (rsp_data.word_index == 3'd7))
      else $error("last word flag out of place");

   // the core takes no job while a digest is waiting
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !q_take)
      else $error("job taken during digest output");
endmodule
